// ----- sv/ofb_pkg.sv -----
// Shared types and constants for the OLED frame buffer refresh core.
package ofb_pkg;

  localparam int unsigned COLUMNS_DEF       = 128;
  localparam int unsigned PAGES_DEF         = 8;
  localparam int unsigned GROUP_COLUMNS_DEF = 32;

  // SSD1306 command bases
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [4:0] COL_HI_CMD    = 5'h10;

  typedef enum logic [1:0] {
    FUNC_POINT   = 2'd0,
    FUNC_FILL    = 2'd1,
    FUNC_REFRESH = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_SCAN,
    ST_REF_END
  } state_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [6:0] x_end;
    logic [5:0] y_end;
    logic       pixel_on;
    logic [2:0] page_sel;
    logic [1:0] group_sel;
  } in_t;

  typedef struct packed {
    logic       write_valid;
    logic [2:0] page_out;
    logic [6:0] column_out;
    logic [7:0] set_page_cmd;
    logic [4:0] col_high_cmd;
    logic [3:0] col_low_cmd;
    logic [7:0] pixel_byte;
    logic       last;
  } out_t;

endpackage

// ----- sv/ofb_ram.sv -----
// Single write port, single registered read port byte store.
module ofb_ram import ofb_pkg::*; #(
  parameter int unsigned DEPTH = PAGES_DEF * COLUMNS_DEF,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ofb_seq.sv -----
// Sequencer: store clearing, byte-wise read-modify-write fill and diff scan.
module ofb_seq import ofb_pkg::*; #(
  parameter int unsigned COLUMNS       = COLUMNS_DEF,
  parameter int unsigned PAGES         = PAGES_DEF,
  parameter int unsigned GROUP_COLUMNS = GROUP_COLUMNS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_data_i,
  output logic in_stall_o,
  input  logic out_free_i,
  output logic res_push_o,
  output out_t res_o,
  output logic clearing_o
);

  localparam int unsigned DEPTH  = PAGES * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned PG_W   = $clog2(PAGES);
  localparam int unsigned ROWS   = PAGES * 8;
  localparam int unsigned SCAN_W = $clog2(4 * GROUP_COLUMNS + COLUMNS + 1);

  localparam logic [8:0]        ColLast9  = 9'(COLUMNS - 1);
  localparam logic [8:0]        RowLast9  = 9'(ROWS - 1);
  localparam logic [8:0]        Cols9     = 9'(COLUMNS);
  localparam logic [8:0]        Rows9     = 9'(ROWS);
  localparam logic [4:0]        Pages5    = 5'(PAGES);
  localparam logic [ADDR_W-1:0] AddrLast  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ColsA     = ADDR_W'(COLUMNS);
  localparam logic [PG_W-1:0]   PageLastP = PG_W'(PAGES - 1);
  localparam logic [SCAN_W-1:0] GroupS    = SCAN_W'(GROUP_COLUMNS);
  localparam logic [SCAN_W-1:0] ColsS     = SCAN_W'(COLUMNS);

  function automatic out_t mk_res(logic vld, logic [2:0] pg, logic [7:0] col,
                                  logic [7:0] data, logic lst);
    out_t r;
    r = '0;
    r.write_valid = vld;
    r.last        = lst;
    if (vld) begin
      r.page_out     = pg;
      r.column_out   = col[6:0];
      r.set_page_cmd = PAGE_CMD_BASE + 8'(pg);
      r.col_high_cmd = COL_HI_CMD | 5'(col[7:4]);
      r.col_low_cmd  = col[3:0];
      r.pixel_byte   = data;
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  // fill walk
  logic [COL_W-1:0]  x_cur_q, x_cur_d, x_last_q, x_last_d;
  logic [PG_W-1:0]   rg_cur_q, rg_cur_d, rg_first_q, rg_first_d, rg_last_q, rg_last_d;
  logic [2:0]        y_lo_q, y_lo_d, y_hi_q, y_hi_d;
  logic              on_q, on_d;
  // refresh scan
  logic [2:0]        page_q, page_d;
  logic [ADDR_W-1:0] page_base_q, page_base_d;
  logic [SCAN_W-1:0] issue_col_q, issue_col_d, scan_end_q, scan_end_d;
  logic [COL_W-1:0]  cmp_col_q, cmp_col_d;
  logic              rd_vld_q, rd_vld_d;
  logic              pend_vld_q, pend_vld_d;
  logic [7:0]        pend_col_q, pend_col_d;
  logic [7:0]        pend_byte_q, pend_byte_d;

  // RAM ports
  logic              fr_we, fr_re, sh_we, sh_re;
  logic [ADDR_W-1:0] fr_waddr, fr_raddr, sh_waddr, sh_raddr;
  logic [7:0]        fr_wdata, sh_wdata, fr_rdata, sh_rdata;

  // accept decode
  logic [8:0] xs9, ys9, xl9, yl9, xlc9, ylc9;
  logic       is_point, go_fill, page_ok;
  logic [SCAN_W-1:0] scan_start, scan_end_raw;

  assign xs9      = {1'b0, in_data_i.x_pos};
  assign ys9      = {1'b0, in_data_i.y_pos};
  assign is_point = (in_data_i.func == FUNC_POINT);
  assign xl9      = is_point ? xs9 : 9'(in_data_i.x_end);
  assign yl9      = is_point ? ys9 : 9'(in_data_i.y_end);
  assign xlc9     = (xl9 > ColLast9) ? ColLast9 : xl9;
  assign ylc9     = (yl9 > RowLast9) ? RowLast9 : yl9;
  assign go_fill  = (xs9 <= xl9) && (ys9 <= yl9) && (xs9 < Cols9) && (ys9 < Rows9);
  assign page_ok  = ({2'b00, in_data_i.page_sel} < Pages5);
  assign scan_start   = SCAN_W'(in_data_i.group_sel) * GroupS;
  assign scan_end_raw = scan_start + GroupS;

  // fill byte under work
  logic [PG_W-1:0]   fill_page;
  logic [ADDR_W-1:0] fill_addr;
  logic [2:0]        m_lo, m_hi;
  logic [7:0]        fill_mask, fill_data;
  logic              fill_done;

  assign fill_page = PageLastP - rg_cur_q;
  assign fill_addr = ADDR_W'(fill_page) * ColsA + ADDR_W'(x_cur_q);
  assign m_lo      = (rg_cur_q == rg_first_q) ? y_lo_q : 3'd0;
  assign m_hi      = (rg_cur_q == rg_last_q) ? y_hi_q : 3'd7;
  // rows lo..hi of this page map to bits 7-lo down to 7-hi
  assign fill_mask = (8'hFF >> m_lo) & (8'hFF << (3'd7 - m_hi));
  assign fill_data = on_q ? (fr_rdata | fill_mask) : (fr_rdata & ~fill_mask);
  assign fill_done = (rg_cur_q == rg_last_q) && (x_cur_q == x_last_q);

  // scan compare
  logic diff, hold, issue_ok;
  assign diff     = rd_vld_q && (fr_rdata != sh_rdata);
  assign hold     = diff && pend_vld_q && !out_free_i;
  assign issue_ok = (issue_col_q < scan_end_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign clearing_o = (state_q == ST_CLEAR);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AddrLast) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.func)
            FUNC_POINT, FUNC_FILL: begin
              if (go_fill) state_d = ST_FILL_RD;
            end
            FUNC_REFRESH: state_d = ST_SCAN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL_RD: state_d = ST_FILL_WR;
      ST_FILL_WR: begin
        state_d = fill_done ? ST_IDLE : ST_FILL_RD;
      end
      ST_SCAN: begin
        if (!hold && !issue_ok && !rd_vld_q) state_d = ST_REF_END;
      end
      ST_REF_END: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_addr_d  = clr_addr_q;
    x_cur_d     = x_cur_q;
    x_last_d    = x_last_q;
    rg_cur_d    = rg_cur_q;
    rg_first_d  = rg_first_q;
    rg_last_d   = rg_last_q;
    y_lo_d      = y_lo_q;
    y_hi_d      = y_hi_q;
    on_d        = on_q;
    page_d      = page_q;
    page_base_d = page_base_q;
    issue_col_d = issue_col_q;
    scan_end_d  = scan_end_q;
    cmp_col_d   = cmp_col_q;
    rd_vld_d    = rd_vld_q;
    pend_vld_d  = pend_vld_q;
    pend_col_d  = pend_col_q;
    pend_byte_d = pend_byte_q;

    fr_we    = 1'b0;
    fr_waddr = fill_addr;
    fr_wdata = fill_data;
    fr_re    = 1'b0;
    fr_raddr = fill_addr;
    sh_we    = 1'b0;
    sh_waddr = page_base_q + ADDR_W'(cmp_col_q);
    sh_wdata = fr_rdata;
    sh_re    = 1'b0;
    sh_raddr = page_base_q + ADDR_W'(issue_col_q);

    res_push_o = 1'b0;
    res_o      = mk_res(1'b1, page_q, pend_col_q, pend_byte_q, 1'b0);

    case (state_q)
      ST_CLEAR: begin
        fr_we      = 1'b1;
        fr_waddr   = clr_addr_q;
        fr_wdata   = '0;
        sh_we      = 1'b1;
        sh_waddr   = clr_addr_q;
        sh_wdata   = '0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        x_cur_d     = COL_W'(xs9);
        x_last_d    = COL_W'(xlc9);
        rg_cur_d    = PG_W'(ys9 >> 3);
        rg_first_d  = PG_W'(ys9 >> 3);
        rg_last_d   = PG_W'(ylc9 >> 3);
        y_lo_d      = ys9[2:0];
        y_hi_d      = ylc9[2:0];
        on_d        = in_data_i.pixel_on;
        page_d      = in_data_i.page_sel;
        page_base_d = ADDR_W'(PG_W'(in_data_i.page_sel)) * ColsA;
        issue_col_d = scan_start;
        if (!page_ok) begin
          scan_end_d = scan_start;
        end else if (scan_end_raw > ColsS) begin
          scan_end_d = ColsS;
        end else begin
          scan_end_d = scan_end_raw;
        end
        rd_vld_d   = 1'b0;
        pend_vld_d = 1'b0;
      end
      ST_FILL_RD: begin
        fr_re = 1'b1;
      end
      ST_FILL_WR: begin
        fr_we = 1'b1;
        if (rg_cur_q == rg_last_q) begin
          rg_cur_d = rg_first_q;
          x_cur_d  = x_cur_q + COL_W'(1);
        end else begin
          rg_cur_d = rg_cur_q + PG_W'(1);
        end
      end
      ST_SCAN: begin
        if (!hold) begin
          if (diff) begin
            sh_we       = 1'b1;
            res_push_o  = pend_vld_q;
            pend_vld_d  = 1'b1;
            pend_col_d  = 8'(cmp_col_q);
            pend_byte_d = fr_rdata;
          end
          if (issue_ok) begin
            fr_re       = 1'b1;
            fr_raddr    = page_base_q + ADDR_W'(issue_col_q);
            sh_re       = 1'b1;
            cmp_col_d   = COL_W'(issue_col_q);
            issue_col_d = issue_col_q + SCAN_W'(1);
            rd_vld_d    = 1'b1;
          end else begin
            rd_vld_d = 1'b0;
          end
        end
      end
      ST_REF_END: begin
        res_o      = mk_res(pend_vld_q, page_q, pend_col_q, pend_byte_q, 1'b1);
        res_push_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      rd_vld_q   <= rd_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_cur_q     <= x_cur_d;
    x_last_q    <= x_last_d;
    rg_cur_q    <= rg_cur_d;
    rg_first_q  <= rg_first_d;
    rg_last_q   <= rg_last_d;
    y_lo_q      <= y_lo_d;
    y_hi_q      <= y_hi_d;
    on_q        <= on_d;
    page_q      <= page_d;
    page_base_q <= page_base_d;
    issue_col_q <= issue_col_d;
    scan_end_q  <= scan_end_d;
    cmp_col_q   <= cmp_col_d;
    pend_col_q  <= pend_col_d;
    pend_byte_q <= pend_byte_d;
  end

  ofb_ram #(.DEPTH(DEPTH), .WIDTH(8)) u_frame (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  ofb_ram #(.DEPTH(DEPTH), .WIDTH(8)) u_shadow (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_waddr),
    .wdata_i (sh_wdata),
    .re_i    (sh_re),
    .raddr_i (sh_raddr),
    .rdata_o (sh_rdata)
  );

endmodule

// ----- sv/oled_frame_buffer_diff_refresh_core.sv -----
// Top level: frame/shadow store sequencer with registered result output.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_stall_i| out_data_o (out_t)
//
// After reset both stores are zeroed, one address per cycle over all PAGES*COLUMNS
// addresses (1024 by default), with in_stall_o high.
// Point and fill: each touched byte (columns x pages spanned) is read from the
// frame store, then written back with the pixel mask applied, one byte at a time.
// Refresh: one byte of each store compared per cycle over the selected group (cut
// short at the last column); a full output register stalls the scan.
// One item at a time.
module oled_frame_buffer_diff_refresh_core import ofb_pkg::*; #(
  parameter int unsigned COLUMNS       = COLUMNS_DEF,
  parameter int unsigned PAGES         = PAGES_DEF,
  parameter int unsigned GROUP_COLUMNS = GROUP_COLUMNS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic out_valid_q, out_valid_d;
  out_t out_data_q;
  logic out_free, res_push, clearing;
  out_t res;

  assign out_free = !out_valid_q || !out_stall_i;

  ofb_seq #(
    .COLUMNS       (COLUMNS),
    .PAGES         (PAGES),
    .GROUP_COLUMNS (GROUP_COLUMNS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .res_push_o (res_push),
    .res_o      (res),
    .clearing_o (clearing)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a result is only loaded when the output register can take it
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> out_free)
    else $error("result pushed into a full output register");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o)
    else $error("input taken while stores are being cleared");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push && !res.write_valid |-> res.last && (res.pixel_byte == 8'h00))
    else $error("nothing-changed transfer malformed");

endmodule

// ----- sim/oled_fb_refresh_checker.sv -----
// Checker for the frame buffer refresh core: watches both channels and compares against a local store model.
module oled_fb_refresh_checker import ofb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   mismatches_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPAGES = PAGES_DEF;
  localparam int unsigned NCOLS  = COLUMNS_DEF;
  localparam int unsigned NGROUP = GROUP_COLUMNS_DEF;

  logic [7:0] frame_img  [NPAGES][NCOLS];
  logic [7:0] shadow_img [NPAGES][NCOLS];
  out_t       panel_writes_q[$];
  out_t       want;

  function automatic void paint_pixel(int unsigned x, int unsigned y, logic on);
    int unsigned pg;
    logic [7:0]  mask;
    if (x >= NCOLS || y >= NPAGES * 8) return;
    pg   = NPAGES - 1 - y / 8;
    mask = 8'h80 >> (y % 8);
    if (on) frame_img[pg][x] = frame_img[pg][x] | mask;
    else frame_img[pg][x] = frame_img[pg][x] & ~mask;
  endfunction

  // Diff one page/group against the shadow and queue the panel writes it causes.
  function automatic void scan_column_group(logic [2:0] pg, logic [1:0] grp);
    int unsigned dirty_cols[$];
    int unsigned col;
    out_t        r;
    if (pg < NPAGES) begin
      for (int unsigned i = 0; i < NGROUP; i++) begin
        col = grp * NGROUP + i;
        if (col >= NCOLS) break;
        if (frame_img[pg][col] != shadow_img[pg][col]) begin
          dirty_cols.push_back(col);
          shadow_img[pg][col] = frame_img[pg][col];
        end
      end
    end
    if (dirty_cols.size() == 0) begin
      r      = '0;
      r.last = 1'b1;
      panel_writes_q.push_back(r);
    end
    foreach (dirty_cols[k]) begin
      col            = dirty_cols[k];
      r              = '0;
      r.write_valid  = 1'b1;
      r.page_out     = pg;
      r.column_out   = col[6:0];
      r.set_page_cmd = PAGE_CMD_BASE + {5'd0, pg};
      r.col_high_cmd = COL_HI_CMD | {2'd0, col[6:4]};
      r.col_low_cmd  = col[3:0];
      r.pixel_byte   = frame_img[pg][col];
      r.last         = (k == dirty_cols.size() - 1);
      panel_writes_q.push_back(r);
    end
  endfunction

  function automatic void apply_command(in_t it);
    case (it.func)
      FUNC_POINT: paint_pixel(it.x_pos, it.y_pos, it.pixel_on);
      FUNC_FILL: begin
        if (it.x_pos <= it.x_end && it.y_pos <= it.y_end) begin
          for (int unsigned x = it.x_pos; x <= it.x_end; x++)
            for (int unsigned y = it.y_pos; y <= it.y_end; y++)
              paint_pixel(x, y, it.pixel_on);
        end
      end
      FUNC_REFRESH: scan_column_group(it.page_sel, it.group_sel);
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (frame_img[p, c]) begin
        frame_img[p][c]  = '0;
        shadow_img[p][c] = '0;
      end
      panel_writes_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // results first: a transfer on this edge can never belong to the item accepted on it
      if (out_valid_i && !out_stall_i) begin
        if (panel_writes_q.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_data_i);
          mismatches_o++;
        end else begin
          want = panel_writes_q.pop_front();
          check_field("write_valid", want.write_valid, out_data_i.write_valid);
          check_field("page_out", want.page_out, out_data_i.page_out);
          check_field("column_out", want.column_out, out_data_i.column_out);
          check_field("set_page_cmd", want.set_page_cmd, out_data_i.set_page_cmd);
          check_field("col_high_cmd", want.col_high_cmd, out_data_i.col_high_cmd);
          check_field("col_low_cmd", want.col_low_cmd, out_data_i.col_low_cmd);
          check_field("pixel_byte", want.pixel_byte, out_data_i.pixel_byte);
          check_field("last", want.last, out_data_i.last);
        end
      end
      if (in_valid_i && !in_stall_i) apply_command(in_data_i);
      pending_o = panel_writes_q.size();
    end
  end

endmodule

// ----- sim/oled_frame_buffer_diff_refresh_core_tb.sv -----
// Testbench top for the frame buffer refresh core: clock, reset, stimulus and verdict.
module oled_frame_buffer_diff_refresh_core_tb import ofb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 160;
  localparam int CALM_TAIL   = 40;
  localparam int HOLD_CYCLES = 300;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  int         mismatches;
  int         pending;
  bit         quiet;
  bit         hold_req;
  logic [2:0] hot_page;
  logic [1:0] hot_grp;

  oled_frame_buffer_diff_refresh_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  oled_fb_refresh_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("oled_frame_buffer_diff_refresh_core verification failed");
    $finish;
  end

  // Random noise in every field; builders overwrite the ones that matter.
  function automatic in_t noise_bits();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_t)-1:0];
  endfunction

  function automatic in_t point_cmd(logic [7:0] x, logic [7:0] y, logic on);
    in_t it;
    it          = noise_bits();
    it.func     = FUNC_POINT;
    it.x_pos    = x;
    it.y_pos    = y;
    it.pixel_on = on;
    return it;
  endfunction

  function automatic in_t fill_cmd(logic [7:0] xs, logic [7:0] ys, logic [6:0] xe,
                                   logic [5:0] ye, logic on);
    in_t it;
    it          = noise_bits();
    it.func     = FUNC_FILL;
    it.x_pos    = xs;
    it.y_pos    = ys;
    it.x_end    = xe;
    it.y_end    = ye;
    it.pixel_on = on;
    return it;
  endfunction

  function automatic in_t refresh_cmd(logic [2:0] pg, logic [1:0] grp);
    in_t it;
    it           = noise_bits();
    it.func      = FUNC_REFRESH;
    it.page_sel  = pg;
    it.group_sel = grp;
    return it;
  endfunction

  // Entered and left at a falling edge; returns once the transfer has happened.
  task automatic send_item(in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Result side: short random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    in_t         it;
    int unsigned sel;
    int unsigned kind;
    logic [7:0]  xs;
    logic [7:0]  ys;
    logic [6:0]  xe;
    logic [5:0]  ye;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    hot_page   = '0;
    hot_grp    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, off-panel points, reversed rectangles, full fills
    send_item(point_cmd(8'd0, 8'd0, 1'b1));
    send_item(point_cmd(8'd127, 8'd63, 1'b1));
    send_item(point_cmd(8'd128, 8'd5, 1'b1));
    send_item(point_cmd(8'd5, 8'd64, 1'b1));
    send_item(point_cmd(8'd255, 8'd255, 1'b1));
    send_item(refresh_cmd(3'd7, 2'd0));
    send_item(refresh_cmd(3'd0, 2'd3));
    send_item(refresh_cmd(3'd7, 2'd0));
    send_item(refresh_cmd(3'd4, 2'd2));
    send_item(fill_cmd(8'd10, 8'd0, 7'd5, 6'd63, 1'b1));
    send_item(fill_cmd(8'd0, 8'd40, 7'd127, 6'd39, 1'b1));
    send_item(fill_cmd(8'd0, 8'd0, 7'd127, 6'd63, 1'b1));
    send_item(refresh_cmd(3'd3, 2'd1));
    send_item(point_cmd(8'd0, 8'd0, 1'b0));
    send_item(refresh_cmd(3'd7, 2'd0));
    send_item(fill_cmd(8'd0, 8'd0, 7'd127, 6'd63, 1'b0));
    send_item(refresh_cmd(3'd3, 2'd1));
    it      = noise_bits();
    it.func = func_e'(2'd3);
    send_item(it);
    send_item(fill_cmd(8'd30, 8'd5, 7'd33, 6'd20, 1'b1));
    send_item(refresh_cmd(3'd6, 2'd0));
    send_item(refresh_cmd(3'd6, 2'd1));
    send_item(fill_cmd(8'd120, 8'd56, 7'd127, 6'd63, 1'b1));
    send_item(refresh_cmd(3'd0, 2'd3));

    // back-pressure: every byte of two pages dirty, receiver holds off while refreshes queue up
    send_item(fill_cmd(8'd0, 8'd0, 7'd127, 6'd63, 1'b1));
    hold_req = 1'b1;
    for (int g = 0; g < 4; g++) begin
      send_item(refresh_cmd(3'd2, 2'(g)));
      send_item(refresh_cmd(3'd5, 2'(g)));
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= RAND_ITEMS - CALM_TAIL);
      sel   = $urandom_range(0, 99);
      if (sel < 35) begin
        xs = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        ys = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
        if (xs < 128 && ys < 64) begin
          hot_page = 3'(7 - ys / 8);
          hot_grp  = xs[6:5];
        end
        send_item(point_cmd(xs, ys, $urandom_range(0, 3) != 0));
      end else if (sel < 55) begin
        kind = $urandom_range(0, 19);
        xs   = 8'($urandom_range(0, 127));
        ys   = 8'($urandom_range(0, 63));
        if (kind == 0) begin
          xe = 7'($urandom_range(xs, 127));
          ye = 6'($urandom_range(ys, 63));
        end else if (kind == 1) begin
          // mostly reversed or off-panel start
          xs = 8'($urandom);
          ys = 8'($urandom);
          xe = 7'($urandom);
          ye = 6'($urandom);
        end else begin
          xe = (xs + 6 > 127) ? 7'd127 : 7'(xs + $urandom_range(0, 6));
          ye = (ys + 11 > 63) ? 6'd63 : 6'(ys + $urandom_range(0, 11));
        end
        if (xs < 128 && ys < 64) begin
          hot_page = 3'(7 - ys / 8);
          hot_grp  = xs[6:5];
        end
        send_item(fill_cmd(xs, ys, xe, ye, $urandom_range(0, 2) != 0));
      end else if (sel < 95) begin
        if ($urandom_range(0, 9) < 6) send_item(refresh_cmd(hot_page, hot_grp));
        else send_item(refresh_cmd(3'($urandom), 2'($urandom)));
      end else begin
        it      = noise_bits();
        it.func = func_e'(2'd3);
        send_item(it);
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("oled_frame_buffer_diff_refresh_core verification clean");
    end else begin
      $display("oled_frame_buffer_diff_refresh_core verification failed");
    end
    $finish;
  end

endmodule
